/* src/rbs_pkg.sv */
// Shared constants and types for the ray versus box slab test.
// Used by every module of the block; depends on nothing.
package rbs_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int LANES      = 3;
    // Magnitude of (corner - origin) needs COORD_BITS + 1 bits before the shift.
    localparam int NUM_W      = COORD_BITS + 1 + FRAC_BITS;
    localparam int DEN_W      = COORD_BITS;
    // Input preparation, one stage per quotient bit, lane result register.
    localparam int PIPE_D     = NUM_W + 2;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    localparam coord_t T_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t T_ZERO = '0;

    typedef struct packed {
        logic   par_miss;
        logic   active;
        coord_t t0;
        coord_t t1;
    } lane_res_t;

endpackage

/* src/rbs_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with sign carried alongside.
// Depends on rbs_pkg.
module rbs_div (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [rbs_pkg::NUM_W-1:0]   num,
    input  logic [rbs_pkg::DEN_W-1:0]   den,
    input  logic                        neg,
    output logic [rbs_pkg::NUM_W-1:0]   quo,
    output logic                        quo_neg
);

    logic [rbs_pkg::DEN_W-1:0] rem_reg [rbs_pkg::NUM_W];
    logic [rbs_pkg::DEN_W-1:0] rem_next [rbs_pkg::NUM_W];
    logic [rbs_pkg::NUM_W-1:0] num_reg [rbs_pkg::NUM_W];
    logic [rbs_pkg::NUM_W-1:0] num_next [rbs_pkg::NUM_W];
    logic [rbs_pkg::NUM_W-1:0] quo_reg [rbs_pkg::NUM_W];
    logic [rbs_pkg::NUM_W-1:0] quo_next [rbs_pkg::NUM_W];
    logic [rbs_pkg::DEN_W-1:0] den_reg [rbs_pkg::NUM_W];
    logic [rbs_pkg::DEN_W-1:0] den_next [rbs_pkg::NUM_W];
    logic                      neg_reg [rbs_pkg::NUM_W];
    logic                      neg_next [rbs_pkg::NUM_W];

    always_comb begin
        logic [rbs_pkg::DEN_W-1:0] rp;
        logic [rbs_pkg::NUM_W-1:0] np;
        logic [rbs_pkg::NUM_W-1:0] qp;
        logic [rbs_pkg::DEN_W-1:0] dp;
        logic [rbs_pkg::DEN_W:0]   tr;
        logic                      ge;
        for (int k = 0; k < rbs_pkg::NUM_W; k++) begin
            if (k == 0) begin
                rp = '0;
                np = num;
                qp = '0;
                dp = den;
                neg_next[k] = neg;
            end else begin
                rp = rem_reg[k-1];
                np = num_reg[k-1];
                qp = quo_reg[k-1];
                dp = den_reg[k-1];
                neg_next[k] = neg_reg[k-1];
            end
            tr = {rp, np[rbs_pkg::NUM_W-1]};
            ge = (tr >= {1'b0, dp});
            rem_next[k] = ge ? rbs_pkg::DEN_W'(tr - {1'b0, dp}) : tr[rbs_pkg::DEN_W-1:0];
            num_next[k] = {np[rbs_pkg::NUM_W-2:0], 1'b0};
            quo_next[k] = {qp[rbs_pkg::NUM_W-2:0], ge};
            den_next[k] = dp;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < rbs_pkg::NUM_W; k++) begin
                rem_reg[k] <= rem_next[k];
                num_reg[k] <= num_next[k];
                quo_reg[k] <= quo_next[k];
                den_reg[k] <= den_next[k];
                neg_reg[k] <= neg_next[k];
            end
        end
    end

    assign quo     = quo_reg[rbs_pkg::NUM_W-1];
    assign quo_neg = neg_reg[rbs_pkg::NUM_W-1];

endmodule

/* src/rbs_lane.sv */
// One axis of the slab test: operand preparation, two slab dividers, saturation and ordering.
// Depends on rbs_pkg and rbs_div.
module rbs_lane (
    input  logic                 aclk,
    input  logic                 en,
    input  rbs_pkg::coord_t      org,
    input  rbs_pkg::coord_t      dir,
    input  rbs_pkg::coord_t      bmin,
    input  rbs_pkg::coord_t      bmax,
    output rbs_pkg::lane_res_t   res
);

    localparam int C = rbs_pkg::COORD_BITS;

    logic [rbs_pkg::NUM_W-1:0] num_lo_reg, num_hi_reg;
    logic [rbs_pkg::DEN_W-1:0] den_reg;
    logic                      neg_lo_reg, neg_hi_reg;
    logic                      par_reg [rbs_pkg::NUM_W+1];
    logic                      inslab_reg [rbs_pkg::NUM_W+1];
    rbs_pkg::lane_res_t        res_reg;

    logic signed [C:0]         diff_lo, diff_hi;
    logic [C:0]                mag_lo, mag_hi;
    logic                      dneg;
    logic [rbs_pkg::NUM_W-1:0] q_lo, q_hi;
    logic                      qn_lo, qn_hi;
    rbs_pkg::coord_t           sa, sb;

    function automatic rbs_pkg::coord_t sat(input logic [rbs_pkg::NUM_W-1:0] q,
                                            input logic n);
        logic [rbs_pkg::NUM_W-1:0] lim;
        logic [rbs_pkg::NUM_W-1:0] qc;
        lim = rbs_pkg::NUM_W'(rbs_pkg::T_MAX) + (n ? rbs_pkg::NUM_W'(1) : '0);
        qc  = (q > lim) ? lim : q;
        return n ? rbs_pkg::coord_t'(C'(-qc)) : rbs_pkg::coord_t'(qc[C-1:0]);
    endfunction

    always_comb begin
        diff_lo = (C+1)'(bmin) - (C+1)'(org);
        diff_hi = (C+1)'(bmax) - (C+1)'(org);
        mag_lo  = diff_lo[C] ? (C+1)'(-diff_lo) : diff_lo;
        mag_hi  = diff_hi[C] ? (C+1)'(-diff_hi) : diff_hi;
        dneg    = dir[C-1];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_lo_reg    <= {mag_lo, {rbs_pkg::FRAC_BITS{1'b0}}};
            num_hi_reg    <= {mag_hi, {rbs_pkg::FRAC_BITS{1'b0}}};
            den_reg       <= dneg ? C'(-dir) : dir;
            neg_lo_reg    <= diff_lo[C] ^ dneg;
            neg_hi_reg    <= diff_hi[C] ^ dneg;
            par_reg[0]    <= (dir == rbs_pkg::T_ZERO);
            inslab_reg[0] <= !((org < bmin) || (org > bmax));
            for (int k = 1; k <= rbs_pkg::NUM_W; k++) begin
                par_reg[k]    <= par_reg[k-1];
                inslab_reg[k] <= inslab_reg[k-1];
            end
            res_reg <= '{par_miss: par_reg[rbs_pkg::NUM_W] && !inslab_reg[rbs_pkg::NUM_W],
                         active:   !par_reg[rbs_pkg::NUM_W],
                         t0:       (sa > sb) ? sb : sa,
                         t1:       (sa > sb) ? sa : sb};
        end
    end

    rbs_div u_div_lo (
        .aclk(aclk), .en(en), .num(num_lo_reg), .den(den_reg), .neg(neg_lo_reg),
        .quo(q_lo), .quo_neg(qn_lo)
    );

    rbs_div u_div_hi (
        .aclk(aclk), .en(en), .num(num_hi_reg), .den(den_reg), .neg(neg_hi_reg),
        .quo(q_hi), .quo_neg(qn_hi)
    );

    assign sa  = sat(q_lo, qn_lo);
    assign sb  = sat(q_hi, qn_hi);
    assign res = res_reg;

endmodule

/* src/rbs_merge.sv */
// Folds the three axis results into hit, entry and exit distances.
// Depends on rbs_pkg.
module rbs_merge (
    input  rbs_pkg::lane_res_t lane [rbs_pkg::LANES],
    output logic               hit,
    output rbs_pkg::coord_t    t_enter,
    output rbs_pkg::coord_t    t_exit
);

    always_comb begin
        rbs_pkg::coord_t tin;
        rbs_pkg::coord_t tout;
        logic            miss;
        tin  = rbs_pkg::T_ZERO;
        tout = rbs_pkg::T_MAX;
        miss = 1'b0;
        for (int a = 0; a < rbs_pkg::LANES; a++) begin
            if (lane[a].par_miss) begin
                miss = 1'b1;
            end
            if (lane[a].active && (lane[a].t0 > tin)) begin
                tin = lane[a].t0;
            end
            if (lane[a].active && (lane[a].t1 < tout)) begin
                tout = lane[a].t1;
            end
        end
        hit     = !miss && !(tout < tin);
        t_enter = hit ? tin : rbs_pkg::T_ZERO;
        t_exit  = hit ? tout : rbs_pkg::T_ZERO;
    end

endmodule

/* src/ray_box_slab_test.sv */
// Top level of the ray versus axis-aligned box slab test.
// Depends on rbs_pkg, rbs_lane (with rbs_div) and rbs_merge.
//
// Usage
// The input channel (s_valid / s_ready) carries one word per test: the ray
// origin, ray direction and the box's minimum and maximum corners, each a
// signed Q16.16 value per axis. The result channel (m_valid / m_ready)
// returns one word per test: m_hit and the entry and exit distances, both
// zero on a miss.
// Three axis lanes run side by side, each with two bit-per-stage dividers
// for its slab distances; a merging stage folds the lanes into the result.
// From acceptance to m_valid a word passes the preparation stage, which the
// accepting edge loads, then one stage per quotient bit (49 at Q16.16), the
// lane result register and the output register. Throughput is one word per
// cycle while the output is not stalled, set by the fully pipelined dividers.
// The whole pipeline moves as one: while the output register holds a word
// that the receiver does not take, every stage holds and s_ready is low.
// Synchronous active-low reset clears the stage valid flags and m_valid;
// data registers are not reset.
module ray_box_slab_test (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  rbs_pkg::coord_t s_origin_x,
    input  rbs_pkg::coord_t s_origin_y,
    input  rbs_pkg::coord_t s_origin_z,
    input  rbs_pkg::coord_t s_dir_x,
    input  rbs_pkg::coord_t s_dir_y,
    input  rbs_pkg::coord_t s_dir_z,
    input  rbs_pkg::coord_t s_box_min_x,
    input  rbs_pkg::coord_t s_box_min_y,
    input  rbs_pkg::coord_t s_box_min_z,
    input  rbs_pkg::coord_t s_box_max_x,
    input  rbs_pkg::coord_t s_box_max_y,
    input  rbs_pkg::coord_t s_box_max_z,
    output logic            m_valid,
    input  logic            m_ready,
    output logic            m_hit,
    output rbs_pkg::coord_t m_t_enter,
    output rbs_pkg::coord_t m_t_exit
);

    // Pipeline advance: the output register is empty or being emptied.
    logic                 adv;
    logic [rbs_pkg::PIPE_D-1:0] vld_reg, vld_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 hit_reg;
    rbs_pkg::coord_t      t_enter_reg, t_exit_reg;
    rbs_pkg::lane_res_t   lane_res [rbs_pkg::LANES];
    logic                 mg_hit;
    rbs_pkg::coord_t      mg_enter, mg_exit;

    rbs_pkg::coord_t org_a [rbs_pkg::LANES];
    rbs_pkg::coord_t dir_a [rbs_pkg::LANES];
    rbs_pkg::coord_t min_a [rbs_pkg::LANES];
    rbs_pkg::coord_t max_a [rbs_pkg::LANES];

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    assign org_a = '{s_origin_x, s_origin_y, s_origin_z};
    assign dir_a = '{s_dir_x, s_dir_y, s_dir_z};
    assign min_a = '{s_box_min_x, s_box_min_y, s_box_min_z};
    assign max_a = '{s_box_max_x, s_box_max_y, s_box_max_z};

    for (genvar a = 0; a < rbs_pkg::LANES; a++) begin : g_lane
        rbs_lane u_lane (
            .aclk(aclk), .en(adv),
            .org(org_a[a]), .dir(dir_a[a]), .bmin(min_a[a]), .bmax(max_a[a]),
            .res(lane_res[a])
        );
    end

    rbs_merge u_merge (
        .lane(lane_res), .hit(mg_hit), .t_enter(mg_enter), .t_exit(mg_exit)
    );

    // Valid flags shift alongside the data; a stall freezes them all.
    always_comb begin
        vld_next     = vld_reg;
        m_valid_next = m_valid_reg;
        if (adv) begin
            vld_next     = {vld_reg[rbs_pkg::PIPE_D-2:0], s_valid};
            m_valid_next = vld_reg[rbs_pkg::PIPE_D-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            vld_reg     <= vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hit_reg     <= mg_hit;
            t_enter_reg <= mg_enter;
            t_exit_reg  <= mg_exit;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_hit     = hit_reg;
    assign m_t_enter = t_enter_reg;
    assign m_t_exit  = t_exit_reg;

    // A miss always reports zero distances.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !hit_reg |-> t_enter_reg == rbs_pkg::T_ZERO &&
                                    t_exit_reg == rbs_pkg::T_ZERO)
        else $error("miss with nonzero distances");

    // A hit never enters behind the origin nor after it exits.
    a_hit_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && hit_reg |-> t_enter_reg >= rbs_pkg::T_ZERO &&
                                   t_enter_reg <= t_exit_reg)
        else $error("hit with inconsistent distances");

    // A stalled result is neither dropped nor altered.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg && $stable(hit_reg) &&
                                    $stable(t_enter_reg) && $stable(t_exit_reg))
        else $error("stalled result changed");

    // During a stall nothing enters or moves inside the pipeline.
    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

endmodule

/* verif/tb.sv */
// Self-checking testbench for the ray versus axis-aligned box slab test.
// Depends on rbs_pkg and the ray_box_slab_test top level; needs nothing else.
`timescale 1ns / 1ps

module tb;

    typedef struct {
        rbs_pkg::coord_t org [3];
        rbs_pkg::coord_t dir [3];
        rbs_pkg::coord_t bmin [3];
        rbs_pkg::coord_t bmax [3];
    } ray_box_t;

    typedef struct {
        logic            hit;
        rbs_pkg::coord_t t_enter;
        rbs_pkg::coord_t t_exit;
    } slab_res_t;

    // Scoreboard: computes the expected result of each accepted word and checks
    // results in order against the queue of pending expectations.
    class slab_board;
        slab_res_t pending[$];
        int        errors;

        // Signed quotient ((corner - origin) << FRAC_BITS) / dir, truncated
        // towards zero, then saturated to the coordinate range.
        function rbs_pkg::coord_t slab_dist(rbs_pkg::coord_t corner, rbs_pkg::coord_t org,
                                            rbs_pkg::coord_t dir);
            logic signed [127:0] num;
            logic signed [127:0] den;
            logic signed [127:0] q;
            num = (128'(signed'(corner)) - 128'(signed'(org))) <<< rbs_pkg::FRAC_BITS;
            den = 128'(signed'(dir));
            q   = num / den;
            if (q > 128'(signed'(rbs_pkg::T_MAX)))
                return rbs_pkg::T_MAX;
            if (q < -128'(signed'(rbs_pkg::T_MAX)) - 1)
                return {1'b1, {(rbs_pkg::COORD_BITS-1){1'b0}}};
            return rbs_pkg::coord_t'(q);
        endfunction

        function void note_input(ray_box_t w);
            slab_res_t       r;
            rbs_pkg::coord_t t0, t1, tmp;
            r.hit = 1'b1;
            r.t_enter = rbs_pkg::T_ZERO;
            r.t_exit = rbs_pkg::T_MAX;
            for (int a = 0; a < 3 && r.hit; a++) begin
                if (w.dir[a] == 0) begin
                    // A ray parallel to a slab misses unless it starts inside it.
                    if (w.org[a] < w.bmin[a] || w.org[a] > w.bmax[a])
                        r.hit = 1'b0;
                    continue;
                end
                t0 = slab_dist(w.bmin[a], w.org[a], w.dir[a]);
                t1 = slab_dist(w.bmax[a], w.org[a], w.dir[a]);
                if (t0 > t1) begin
                    tmp = t0;
                    t0 = t1;
                    t1 = tmp;
                end
                if (t0 > r.t_enter)
                    r.t_enter = t0;
                if (t1 < r.t_exit)
                    r.t_exit = t1;
                if (r.t_exit < r.t_enter)
                    r.hit = 1'b0;
            end
            if (!r.hit) begin
                r.t_enter = rbs_pkg::T_ZERO;
                r.t_exit = rbs_pkg::T_ZERO;
            end
            pending = {pending, r};
        endfunction

        function void check_result(logic hit, rbs_pkg::coord_t t_enter,
                                   rbs_pkg::coord_t t_exit);
            slab_res_t e;
            if (pending.size() == 0) begin
                $error("result word arrived with no expectation pending");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (hit !== e.hit) begin
                $error("hit: expected %0d, got %0d", e.hit, hit);
                errors++;
            end
            if (t_enter !== e.t_enter) begin
                $error("t_enter: expected %0d, got %0d", e.t_enter, t_enter);
                errors++;
            end
            if (t_exit !== e.t_exit) begin
                $error("t_exit: expected %0d, got %0d", e.t_exit, t_exit);
                errors++;
            end
        endfunction
    endclass

    localparam int LATENCY = rbs_pkg::PIPE_D + 1;
    localparam int N_RANDOM = 2000;
    // Anything well past the longest receiver hold-off is a hang.
    localparam int STALL_LIMIT = 5000;

    logic            aclk;
    logic            aresetn;
    logic            s_valid;
    logic            s_ready;
    rbs_pkg::coord_t s_org [3];
    rbs_pkg::coord_t s_dir [3];
    rbs_pkg::coord_t s_bmin [3];
    rbs_pkg::coord_t s_bmax [3];
    logic            m_valid;
    logic            m_ready;
    logic            m_hit;
    rbs_pkg::coord_t m_t_enter;
    rbs_pkg::coord_t m_t_exit;

    slab_board board;
    bit        sending_done;
    int        idle_cycles;

    ray_box_slab_test u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_origin_x  (s_org[0]),
        .s_origin_y  (s_org[1]),
        .s_origin_z  (s_org[2]),
        .s_dir_x     (s_dir[0]),
        .s_dir_y     (s_dir[1]),
        .s_dir_z     (s_dir[2]),
        .s_box_min_x (s_bmin[0]),
        .s_box_min_y (s_bmin[1]),
        .s_box_min_z (s_bmin[2]),
        .s_box_max_x (s_bmax[0]),
        .s_box_max_y (s_bmax[1]),
        .s_box_max_z (s_bmax[2]),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hit       (m_hit),
        .m_t_enter   (m_t_enter),
        .m_t_exit    (m_t_exit)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // A random coordinate: sometimes an extreme, sometimes small, often full range.
    function automatic rbs_pkg::coord_t rand_coord();
        case ($urandom_range(0, 9))
            0: return rbs_pkg::T_MAX;
            1: return {1'b1, {(rbs_pkg::COORD_BITS-1){1'b0}}};
            2: return rbs_pkg::T_ZERO;
            3, 4: return rbs_pkg::coord_t'($signed($urandom_range(0, 32'h0020_0000))
                                           - 32'h0010_0000);
            default: return rbs_pkg::coord_t'($urandom);
        endcase
    endfunction

    // A sensible ray and box in a modest range so that hits are common;
    // about one direction component in ten is forced to zero.
    function automatic ray_box_t rand_scene();
        ray_box_t        w;
        rbs_pkg::coord_t c, h;
        for (int a = 0; a < 3; a++) begin
            c = rbs_pkg::coord_t'($signed($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000);
            h = rbs_pkg::coord_t'($urandom_range(1, 32'h0008_0000));
            w.bmin[a] = c - h;
            w.bmax[a] = c + h;
            w.org[a]  = rbs_pkg::coord_t'($signed($urandom_range(0, 32'h0080_0000))
                                          - 32'h0040_0000);
            w.dir[a]  = ($urandom_range(0, 1) ? c - w.org[a] : rbs_pkg::coord_t'($urandom))
                        >>> $urandom_range(0, 8);
            if ($urandom_range(0, 9) == 0)
                w.dir[a] = rbs_pkg::T_ZERO;
        end
        return w;
    endfunction

    function automatic ray_box_t rand_noise();
        ray_box_t w;
        for (int a = 0; a < 3; a++) begin
            w.org[a]  = rand_coord();
            w.dir[a]  = rand_coord();
            w.bmin[a] = rand_coord();
            w.bmax[a] = rand_coord();
        end
        return w;
    endfunction

    function automatic ray_box_t make_scene(rbs_pkg::coord_t o, rbs_pkg::coord_t d,
                                            rbs_pkg::coord_t lo, rbs_pkg::coord_t hi);
        ray_box_t w;
        for (int a = 0; a < 3; a++) begin
            w.org[a] = o;
            w.dir[a] = d;
            w.bmin[a] = lo;
            w.bmax[a] = hi;
        end
        return w;
    endfunction

    // Offers one word, after a random gap, and holds it until it is taken.
    // Valid only drops for a gap, so back-to-back words keep it high.
    task automatic send_word(ray_box_t w, bit no_gap);
        int g;
        g = no_gap ? 0 : gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_org   <= w.org;
        s_dir   <= w.dir;
        s_bmin  <= w.bmin;
        s_bmax  <= w.bmax;
        do
            @(posedge aclk);
        while (!s_ready);
        board.note_input(w);
    endtask

    // Stimulus: a directed set first, then random scenes and noise.
    initial begin : stimulus
        ray_box_t        dset[$];
        ray_box_t        w;
        rbs_pkg::coord_t one, nmax;
        one  = rbs_pkg::coord_t'(32'h0001_0000);
        nmax = {1'b1, {(rbs_pkg::COORD_BITS-1){1'b0}}};
        board = new();
        s_valid <= 1'b0;
        foreach (s_org[a]) begin
            s_org[a]  <= rbs_pkg::T_ZERO;
            s_dir[a]  <= rbs_pkg::T_ZERO;
            s_bmin[a] <= rbs_pkg::T_ZERO;
            s_bmax[a] <= rbs_pkg::T_ZERO;
        end
        aresetn <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Origin inside the box, ray along the diagonal.
        dset = {dset, make_scene(rbs_pkg::T_ZERO, one, -one, one)};
        // Box ahead of the ray and box behind it.
        dset = {dset, make_scene(rbs_pkg::T_ZERO, one, one, one + one)};
        dset = {dset, make_scene(rbs_pkg::T_ZERO, -one, one, one + one)};
        // No nonzero direction: inside every slab, then outside one.
        dset = {dset, make_scene(rbs_pkg::T_ZERO, rbs_pkg::T_ZERO, -one, one)};
        w = make_scene(rbs_pkg::T_ZERO, rbs_pkg::T_ZERO, -one, one);
        w.org[1] = one + one;
        dset = {dset, w};
        // Parallel on one axis only, inside and outside.
        w = make_scene(rbs_pkg::T_ZERO, one, -one, one);
        w.dir[2] = rbs_pkg::T_ZERO;
        dset = {dset, w};
        w.org[2] = nmax;
        dset = {dset, w};
        // Inverted box, with and without a parallel axis.
        dset = {dset, make_scene(rbs_pkg::T_ZERO, one, one, -one)};
        dset = {dset, make_scene(rbs_pkg::T_ZERO, rbs_pkg::T_ZERO, one, -one)};
        // Saturating quotients in both signs and extreme operands.
        dset = {dset, make_scene(nmax, rbs_pkg::coord_t'(1), nmax, rbs_pkg::T_MAX)};
        dset = {dset, make_scene(rbs_pkg::T_MAX, rbs_pkg::coord_t'(-1), nmax,
                                 rbs_pkg::T_MAX)};
        dset = {dset, make_scene(nmax, nmax, nmax, rbs_pkg::T_MAX)};
        dset = {dset, make_scene(rbs_pkg::T_MAX, rbs_pkg::T_MAX, nmax, rbs_pkg::T_MAX)};
        dset = {dset, make_scene(rbs_pkg::T_MAX, nmax, rbs_pkg::T_MAX, nmax)};
        dset = {dset, make_scene(rbs_pkg::coord_t'(-1), rbs_pkg::coord_t'(-1),
                                 rbs_pkg::coord_t'(-1), rbs_pkg::coord_t'(-1))};
        dset = {dset, make_scene(rbs_pkg::T_ZERO, rbs_pkg::coord_t'(1),
                                 rbs_pkg::coord_t'(-1), rbs_pkg::coord_t'(1))};
        foreach (dset[i])
            send_word(dset[i], 1'b0);

        for (int n = 0; n < N_RANDOM; n++) begin
            w = ($urandom_range(0, 3) == 0) ? rand_noise() : rand_scene();
            // Back-to-back bursts now and then so the pipeline runs full.
            send_word(w, n % 200 < 40);
        end
        s_valid <= 1'b0;
        sending_done = 1'b1;
    end

    // Receiver: random ready, with one long hold-off while the sender keeps
    // offering words so that the pipeline fills and s_ready drops.
    initial begin : receiver
        int accepted;
        int g;
        accepted = 0;
        m_ready <= 1'b0;
        @(posedge aresetn);
        forever begin
            if (accepted == 100) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
            end
            g = (accepted > 600 && accepted < 900) ? 0 : gap_len();
            if (g > 0) begin
                m_ready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do
                @(posedge aclk);
            while (!m_valid);
            accepted++;
        end
    end

    // Sample results on the clock edge at which they are taken.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(m_hit, m_t_enter, m_t_exit);
    end

    // Watchdog on cycles with no handshake on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("ray_box_slab_test: mismatch");
            $finish;
        end
    end

    // End of run: all sent and all results back, then wait on to catch any
    // stray result word.
    initial begin : finisher
        wait (sending_done);
        while (board.pending.size() != 0)
            @(posedge aclk);
        repeat (LATENCY * 2) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("ray_box_slab_test: match");
        else
            $display("ray_box_slab_test: mismatch");
        $finish;
    end

endmodule
